// ===== rtl/adc_pkg.sv =====
// ----------------------------------------------------------------------------
// adc_pkg
// Shared types and constants of the adaptive delayed-ack controller.
// ----------------------------------------------------------------------------
package adc_pkg;

  localparam int unsigned SeqW    = 31;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned LimitW  = 9;
  localparam int unsigned SumW    = 34;
  localparam int unsigned SatW    = 11;
  localparam int unsigned MagW    = 10;
  localparam int unsigned ProdW   = 20;

  // window limit is clamped before the divide by three; the clamp keeps the
  // saturated 9-bit result exact
  localparam logic signed [SumW-1:0] SatHi = 34'sd767;
  localparam logic signed [SumW-1:0] SatLo = -34'sd768;

  // x / 3 == (x * 683) >> 11 for 0 <= x <= 768
  localparam logic [MagW-1:0] RecipThree = 10'd683;
  localparam int unsigned     RecipShift = 11;

  localparam logic [CountW-1:0] CountMax   = 8'd255;
  localparam logic [CountW-1:0] FactorInit = 8'd1;
  localparam logic [CountW-1:0] MaxDelayInit = 8'd4;

  typedef struct packed {
    logic                     ecn_mark;
    logic                     timer_pending;
    logic [TimeW-1:0]         echoed_time;
    logic [TimeW-1:0]         segment_time;
    logic [TimeW-1:0]         current_time;
    logic signed [LimitW-1:0] win_limit;
  } item_t;

  typedef struct packed {
    logic                     send_ack;
    logic [CountW-1:0]        ack_count;
    logic                     arm_timer;
    logic                     cancel_timer;
    logic                     keep_as_saved;
    logic [CountW-1:0]        factor_now;
    logic signed [LimitW-1:0] limit_now;
  } result_t;

  // queue status between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// ===== rtl/adc_front.sv =====
// ----------------------------------------------------------------------------
// adc_front
// Input pipeline: window limit from the sender state, divide by three,
// then a two-entry queue toward the decision logic.
// ----------------------------------------------------------------------------
module adc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [adc_pkg::SeqW-1:0]  segment_seq_i,
  input  logic [adc_pkg::SeqW-1:0]  cumulative_seq_i,
  input  logic                      ecn_mark_i,
  input  logic [adc_pkg::TimeW-1:0] echoed_time_i,
  input  logic [adc_pkg::TimeW-1:0] segment_time_i,
  input  logic [adc_pkg::TimeW-1:0] current_time_i,
  input  logic [adc_pkg::SeqW-1:0]  sender_window_i,
  input  logic [adc_pkg::SeqW-1:0]  sender_highest_ack_i,
  input  logic [adc_pkg::SeqW-1:0]  sender_left_to_send_i,
  input  logic                      timer_pending_i,
  output adc_pkg::qhead_t           head_o,
  input  logic                      take_i
);
  import adc_pkg::*;

  // stage a
  logic                   va_q;
  logic                   in_order_a_q;
  logic signed [SumW-1:0] sum_a_q;
  logic [SeqW-1:0]        left_a_q;
  item_t                  item_a_q;
  // stage b
  logic                   vb_q;
  logic                   in_order_b_q;
  logic signed [SatW-1:0] sat_b_q;
  item_t                  item_b_q;
  // stage c
  logic                   vc_q;
  item_t                  item_c_q;
  // queue
  item_t                  queue_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q;

  logic                   q_full, q_push, q_pop;
  logic                   ready_a, ready_b, ready_c, accept;
  logic signed [SumW-1:0] sum_d, left_ext, min_b;
  logic signed [SatW-1:0] sat_d;
  logic [SatW-1:0]        mag_full;
  logic [ProdW-1:0]       prod;
  logic [LimitW-1:0]      quot;
  logic signed [LimitW-1:0] lim_c;
  item_t                  item_c_d;

  assign q_full  = (cnt_q == 2'd2);
  assign ready_c = !vc_q || !q_full;
  assign ready_b = !vb_q || ready_c;
  assign ready_a = !va_q || ready_b;
  assign full_o  = !ready_a;
  assign accept  = push_i && ready_a;
  assign q_push  = vc_q && !q_full;
  assign q_pop   = take_i && (cnt_q != 2'd0);

  assign sum_d = $signed({3'b000, sender_window_i}) + $signed({3'b000, cumulative_seq_i})
               - $signed({3'b000, sender_highest_ack_i});

  always_comb begin
    left_ext = $signed({3'b000, left_a_q});
    min_b    = (left_ext < sum_a_q) ? left_ext : sum_a_q;
    if (min_b > SatHi) begin
      sat_d = SatHi[SatW-1:0];
    end else if (min_b < SatLo) begin
      sat_d = SatLo[SatW-1:0];
    end else begin
      sat_d = min_b[SatW-1:0];
    end
  end

  always_comb begin
    mag_full = sat_b_q[SatW-1] ? (~sat_b_q + 11'd1) : sat_b_q;
    prod     = ProdW'(mag_full[MagW-1:0]) * ProdW'(RecipThree);
    quot     = prod[ProdW-1:RecipShift];
    if (!in_order_b_q) begin
      lim_c = '0;
    end else if (sat_b_q[SatW-1]) begin
      lim_c = $signed(~quot + 9'd1);
    end else begin
      lim_c = $signed(quot);
    end
    item_c_d           = item_b_q;
    item_c_d.win_limit = lim_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (ready_a) va_q <= push_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
      if (q_push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_order_a_q           <= (segment_seq_i == cumulative_seq_i);
      sum_a_q                <= sum_d;
      left_a_q               <= sender_left_to_send_i;
      item_a_q.ecn_mark      <= ecn_mark_i;
      item_a_q.timer_pending <= timer_pending_i;
      item_a_q.echoed_time   <= echoed_time_i;
      item_a_q.segment_time  <= segment_time_i;
      item_a_q.current_time  <= current_time_i;
      item_a_q.win_limit     <= '0;
    end
    if (ready_b && va_q) begin
      in_order_b_q <= in_order_a_q;
      sat_b_q      <= sat_d;
      item_b_q     <= item_a_q;
    end
    if (ready_c && vb_q) begin
      item_c_q <= item_c_d;
    end
    if (q_push) queue_q[wr_ptr_q] <= item_c_q;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

// ===== rtl/adc_back.sv =====
// ----------------------------------------------------------------------------
// adc_back
// Decision logic: delay factor, delay limit and pending count, with a
// two-entry result queue.
// ----------------------------------------------------------------------------
module adc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [adc_pkg::CountW-1:0] max_delay_i,
  input  adc_pkg::qhead_t            head_i,
  output logic                       take_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output adc_pkg::result_t           result_o
);
  import adc_pkg::*;

  logic [CountW-1:0] pending_q, factor_q;
  logic [TimeW-1:0]  high_echo_q, last_ecn_q, last_dec_q, saved_time_q;
  result_t           queue_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  logic                     q_full, q_pop, do_ecn, do_dec, delay;
  logic [TimeW-1:0]         echo_new;
  logic [CountW:0]          doubled;
  logic [CountW-1:0]        factor_d, pending_inc;
  logic signed [LimitW:0]   lim_cand, lim_cap, lim_fin;
  result_t                  res;
  item_t                    it;

  assign it     = head_i.item;
  assign q_full = (cnt_q == 2'd2);
  assign take_o = head_i.valid && !q_full;
  assign q_pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    echo_new    = (it.echoed_time > high_echo_q) ? it.echoed_time : high_echo_q;
    do_ecn      = it.ecn_mark && (echo_new >= last_ecn_q);
    do_dec      = !do_ecn && (echo_new >= last_ecn_q) && (echo_new >= last_dec_q);
    doubled     = {factor_q, 1'b0};
    factor_d    = factor_q;
    if (do_ecn) begin
      factor_d = (doubled < {1'b0, max_delay_i}) ? doubled[CountW-1:0] : max_delay_i;
    end else if (do_dec) begin
      factor_d = (factor_q > 8'd2) ? factor_q - 8'd1 : FactorInit;
    end
    lim_cand    = {it.win_limit[LimitW-1], it.win_limit};
    lim_cap     = ($signed({2'b00, max_delay_i}) < lim_cand) ? $signed({2'b00, max_delay_i})
                                                              : lim_cand;
    lim_fin     = ($signed({2'b00, factor_d}) < lim_cap) ? $signed({2'b00, factor_d}) : lim_cap;
    pending_inc = (pending_q < CountMax) ? pending_q + 8'd1 : CountMax;
    delay       = $signed({2'b00, pending_inc}) < lim_fin;

    res.send_ack      = !delay;
    res.ack_count     = delay ? '0 : pending_inc;
    res.arm_timer     = delay && !it.timer_pending;
    res.cancel_timer  = !delay && it.timer_pending;
    res.keep_as_saved = delay && (!it.timer_pending || (it.segment_time > saved_time_q));
    res.factor_now    = factor_d;
    res.limit_now     = lim_fin[LimitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      factor_q    <= FactorInit;
      high_echo_q <= '0;
      last_ecn_q  <= '0;
      last_dec_q  <= '0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (take_o) begin
        pending_q   <= delay ? pending_inc : '0;
        factor_q    <= factor_d;
        high_echo_q <= echo_new;
        if (do_ecn) last_ecn_q <= it.current_time;
        if (do_dec) last_dec_q <= it.current_time;
        wr_ptr_q    <= ~wr_ptr_q;
      end
      if (q_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, take_o} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      queue_q[wr_ptr_q] <= res;
      if (res.keep_as_saved) saved_time_q <= it.segment_time;
    end
  end

  assign empty_o  = (cnt_q == 2'd0);
  assign result_o = queue_q[rd_ptr_q];

endmodule

// ===== rtl/adaptive_delayed_ack_control.sv =====
// path: stages a, b, c, front queue, decision logic, result queue (empty low)
// throughput: one segment per cycle while full is low and results are popped
// front: three pipeline stages (window sum, clamp, divide by three) + 2-entry queue
// back: 2-entry result queue; empty follows its count, full the front stages and queue
// reset: asynchronous active low; queues empty, factor 1, max delay count 4
// ----------------------------------------------------------------------------
// adaptive_delayed_ack_control
// Decides per received segment whether to acknowledge now or delay.
// ----------------------------------------------------------------------------
module adaptive_delayed_ack_control (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [adc_pkg::SeqW-1:0]   segment_seq_i,
  input  logic [adc_pkg::SeqW-1:0]   cumulative_seq_i,
  input  logic                       ecn_mark_i,
  input  logic [adc_pkg::TimeW-1:0]  echoed_time_i,
  input  logic [adc_pkg::TimeW-1:0]  segment_time_i,
  input  logic [adc_pkg::TimeW-1:0]  current_time_i,
  input  logic [adc_pkg::SeqW-1:0]   sender_window_i,
  input  logic [adc_pkg::SeqW-1:0]   sender_highest_ack_i,
  input  logic [adc_pkg::SeqW-1:0]   sender_left_to_send_i,
  input  logic                       timer_pending_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       send_ack_o,
  output logic [adc_pkg::CountW-1:0] ack_count_o,
  output logic                       arm_timer_o,
  output logic                       cancel_timer_o,
  output logic                       keep_as_saved_o,
  output logic [adc_pkg::CountW-1:0] factor_now_o,
  output logic signed [adc_pkg::LimitW-1:0] limit_now_o,
  input  logic                       cfg_we_i,
  input  logic [adc_pkg::CountW-1:0] cfg_wdata_i
);
  import adc_pkg::*;

  logic [CountW-1:0] max_delay_q;
  qhead_t            head;
  logic              take;
  result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= MaxDelayInit;
    end else if (cfg_we_i) begin
      max_delay_q <= cfg_wdata_i;
    end
  end

  adc_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push_i                (push),
    .full_o                (full),
    .segment_seq_i         (segment_seq_i),
    .cumulative_seq_i      (cumulative_seq_i),
    .ecn_mark_i            (ecn_mark_i),
    .echoed_time_i         (echoed_time_i),
    .segment_time_i        (segment_time_i),
    .current_time_i        (current_time_i),
    .sender_window_i       (sender_window_i),
    .sender_highest_ack_i  (sender_highest_ack_i),
    .sender_left_to_send_i (sender_left_to_send_i),
    .timer_pending_i       (timer_pending_i),
    .head_o                (head),
    .take_i                (take)
  );

  adc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_delay_i (max_delay_q),
    .head_i      (head),
    .take_o      (take),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result)
  );

  assign send_ack_o      = result.send_ack;
  assign ack_count_o     = result.ack_count;
  assign arm_timer_o     = result.arm_timer;
  assign cancel_timer_o  = result.cancel_timer;
  assign keep_as_saved_o = result.keep_as_saved;
  assign factor_now_o    = result.factor_now;
  assign limit_now_o     = result.limit_now;

  a_count_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !send_ack_o) |-> (ack_count_o == '0))
    else $error("ack count without ack");

  a_send_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && send_ack_o) |-> (ack_count_o != '0))
    else $error("ack covers no segment");

  a_arm_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && arm_timer_o) |-> (keep_as_saved_o && !send_ack_o))
    else $error("timer armed without saving segment");

  a_cancel_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cancel_timer_o) |-> (send_ack_o && !arm_timer_o))
    else $error("timer cancelled without ack");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive delayed-ack controller: segment headers
// go in through the push side in random bursts, decisions are popped under a
// changing stall pattern and compared field by field with a local prediction.
// ----------------------------------------------------------------------------
module tb;

  import adc_pkg::*;

  typedef struct {
    logic [SeqW-1:0]  seq;
    logic [SeqW-1:0]  cum;
    logic             ecn;
    logic [TimeW-1:0] echo;
    logic [TimeW-1:0] seg_ts;
    logic [TimeW-1:0] now;
    logic [SeqW-1:0]  win;
    logic [SeqW-1:0]  hi_ack;
    logic [SeqW-1:0]  left;
    logic             timer;
  } seg_hdr_t;

  localparam int QuietLimit = 2000;
  localparam logic [SeqW-1:0]  SeqAllOnes  = '1;
  localparam logic [TimeW-1:0] TimeAllOnes = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [SeqW-1:0] segment_seq_i = '0;
  logic [SeqW-1:0] cumulative_seq_i = '0;
  logic ecn_mark_i = 1'b0;
  logic [TimeW-1:0] echoed_time_i = '0;
  logic [TimeW-1:0] segment_time_i = '0;
  logic [TimeW-1:0] current_time_i = '0;
  logic [SeqW-1:0] sender_window_i = '0;
  logic [SeqW-1:0] sender_highest_ack_i = '0;
  logic [SeqW-1:0] sender_left_to_send_i = '0;
  logic timer_pending_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic send_ack_o;
  logic [CountW-1:0] ack_count_o;
  logic arm_timer_o;
  logic cancel_timer_o;
  logic keep_as_saved_o;
  logic [CountW-1:0] factor_now_o;
  logic signed [LimitW-1:0] limit_now_o;
  logic cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;

  // predicted controller state
  logic [CountW-1:0] max_delay = MaxDelayInit;
  int                unacked_cnt = 0;
  logic [CountW-1:0] factor = FactorInit;
  logic [TimeW-1:0]  top_echo = '0;
  logic [TimeW-1:0]  ecn_time = '0;
  logic [TimeW-1:0]  decr_time = '0;
  logic [TimeW-1:0]  saved_ts = '0;

  seg_hdr_t pending_segs[$];
  result_t  ack_expected[$];
  int errors = 0;

  // stimulus generator state
  logic [TimeW-1:0] tick = 32'd1000;
  logic [SeqW-1:0]  cum_next = 31'd5000;

  // driver and monitor state
  seg_hdr_t hd;
  result_t  want;
  int gap_left = 0;
  int burst_left = 0;
  int cyc = 0;
  int stall_mode = 0;
  int quiet_cycles = 0;

  adaptive_delayed_ack_control i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .segment_seq_i        (segment_seq_i),
    .cumulative_seq_i     (cumulative_seq_i),
    .ecn_mark_i           (ecn_mark_i),
    .echoed_time_i        (echoed_time_i),
    .segment_time_i       (segment_time_i),
    .current_time_i       (current_time_i),
    .sender_window_i      (sender_window_i),
    .sender_highest_ack_i (sender_highest_ack_i),
    .sender_left_to_send_i(sender_left_to_send_i),
    .timer_pending_i      (timer_pending_i),
    .empty                (empty),
    .pop                  (pop),
    .send_ack_o           (send_ack_o),
    .ack_count_o          (ack_count_o),
    .arm_timer_o          (arm_timer_o),
    .cancel_timer_o       (cancel_timer_o),
    .keep_as_saved_o      (keep_as_saved_o),
    .factor_now_o         (factor_now_o),
    .limit_now_o          (limit_now_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  function automatic result_t decide_ack(seg_hdr_t h);
    result_t r;
    longint  w;
    longint  c;
    longint  ha;
    longint  lf;
    longint  md;
    longint  fl;
    longint  can;
    longint  lim;
    int      dbl;
    r = '0;
    if (h.echo > top_echo) top_echo = h.echo;
    if (h.ecn && top_echo >= ecn_time) begin
      dbl = 2 * factor;
      factor = (dbl < max_delay) ? CountW'(dbl) : max_delay;
      ecn_time = h.now;
    end else if (top_echo >= ecn_time && top_echo >= decr_time) begin
      factor = (factor > 8'd2) ? factor - 8'd1 : 8'd1;
      decr_time = h.now;
    end
    md = longint'(max_delay);
    fl = longint'(factor);
    if (h.seq == h.cum) begin
      w = longint'(h.win);
      c = longint'(h.cum);
      ha = longint'(h.hi_ack);
      lf = longint'(h.left);
      can = w + c - ha;
      if (lf < can) can = lf;
      can = can / 3;
      lim = (md < can) ? md : can;
    end else begin
      lim = 0;
    end
    if (fl < lim) lim = fl;
    if (lim < -256) lim = -256;
    if (lim > 255) lim = 255;
    if (unacked_cnt < 255) unacked_cnt++;
    if (unacked_cnt < lim) begin
      if (!h.timer) begin
        saved_ts = h.seg_ts;
        r.arm_timer = 1'b1;
        r.keep_as_saved = 1'b1;
      end else if (h.seg_ts > saved_ts) begin
        saved_ts = h.seg_ts;
        r.keep_as_saved = 1'b1;
      end
    end else begin
      r.cancel_timer = h.timer;
      r.send_ack = 1'b1;
      r.ack_count = CountW'(unacked_cnt);
      unacked_cnt = 0;
    end
    r.factor_now = factor;
    r.limit_now = lim[LimitW-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] exp_v,
                                      logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void add_seg(logic [SeqW-1:0] seq, logic [SeqW-1:0] cum, logic ecn,
                                  logic [TimeW-1:0] echo, logic [TimeW-1:0] seg_ts,
                                  logic [TimeW-1:0] now, logic [SeqW-1:0] win,
                                  logic [SeqW-1:0] hi_ack, logic [SeqW-1:0] left,
                                  logic timer);
    seg_hdr_t h;
    h.seq = seq;
    h.cum = cum;
    h.ecn = ecn;
    h.echo = echo;
    h.seg_ts = seg_ts;
    h.now = now;
    h.win = win;
    h.hi_ack = hi_ack;
    h.left = left;
    h.timer = timer;
    pending_segs.push_back(h);
  endfunction

  function automatic void jump_ticks(int unsigned m);
    logic [TimeW-1:0] base;
    base = m * 32'h2000_0000;
    if (tick < base) tick = base + $urandom_range(0, 1000);
    cum_next = SeqW'($urandom);
  endfunction

  // mostly well-formed arrivals with a steady clock and lagging echo, some noise
  function automatic void gen_traffic(int n);
    int unsigned rtt;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] win;
    logic [SeqW-1:0] left;
    for (int i = 0; i < n; i++) begin
      tick = tick + $urandom_range(1, 40);
      if ($urandom_range(0, 99) < 85) begin
        rtt = $urandom_range(20, 300);
        cum_next = cum_next + SeqW'($urandom_range(0, 3));
        seq = ($urandom_range(0, 4) != 0) ? cum_next
                                           : cum_next + SeqW'($urandom_range(1, 100));
        win = ($urandom_range(0, 9) == 0) ? SeqW'($urandom_range(0, 20))
                                           : SeqW'($urandom_range(0, 1000));
        left = ($urandom_range(0, 9) == 0) ? SeqW'($urandom) : SeqW'($urandom_range(0, 1000));
        add_seg(seq, cum_next, $urandom_range(0, 3) == 0,
                (tick > rtt) ? tick - rtt : '0,
                tick - $urandom_range(0, 200), tick, win,
                cum_next - SeqW'($urandom_range(0, 60)), left, 1'($urandom_range(0, 1)));
      end else begin
        add_seg(SeqW'($urandom), SeqW'($urandom), 1'($urandom_range(0, 1)),
                $urandom_range(0, tick), $urandom, tick, SeqW'($urandom),
                SeqW'($urandom), SeqW'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  // double the factor once per round trip up to its cap, then hold the echo
  // back so it stays there while unacked segments pile up
  function automatic void gen_ramp();
    logic [TimeW-1:0] prev;
    prev = tick;
    for (int i = 0; i < 9; i++) begin
      tick = tick + 10;
      cum_next = cum_next + 31'd1;
      add_seg(cum_next, cum_next, 1'b1, prev, tick - 5, tick, 31'd2000, cum_next, 31'd2000,
              i != 0);
      prev = tick;
    end
    for (int i = 0; i < 258; i++) begin
      tick = tick + $urandom_range(1, 20);
      cum_next = cum_next + 31'd1;
      add_seg(cum_next, cum_next, 1'b0, '0, $urandom, tick, 31'd2000, cum_next, 31'd2000,
              $urandom_range(0, 3) != 0);
    end
  endfunction

  task automatic drain();
    while (pending_segs.size() != 0 || ack_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_delay(logic [CountW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    max_delay = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // segment source
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        ack_expected.push_back(decide_ack(pending_segs.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_segs.size() > 0) begin
        hd = pending_segs[0];
        segment_seq_i <= hd.seq;
        cumulative_seq_i <= hd.cum;
        ecn_mark_i <= hd.ecn;
        echoed_time_i <= hd.echo;
        segment_time_i <= hd.seg_ts;
        current_time_i <= hd.now;
        sender_window_i <= hd.win;
        sender_highest_ack_i <= hd.hi_ack;
        sender_left_to_send_i <= hd.left;
        timer_pending_i <= hd.timer;
        push <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // decision sink
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (ack_expected.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual send_ack %0d factor %0d",
                   $time, send_ack_o, factor_now_o);
          errors++;
        end else begin
          want = ack_expected.pop_front();
          check_field("send_ack", want.send_ack, send_ack_o);
          check_field("ack_count", want.ack_count, ack_count_o);
          check_field("arm_timer", want.arm_timer, arm_timer_o);
          check_field("cancel_timer", want.cancel_timer, cancel_timer_o);
          check_field("keep_as_saved", want.keep_as_saved, keep_as_saved_o);
          check_field("factor_now", want.factor_now, factor_now_o);
          check_field("limit_now", want.limit_now, limit_now_o);
        end
      end
      cyc++;
      if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          pop <= (cyc % 20 < 4);
        end
        default: begin
          pop <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset value of max delay count
    // first segment is delayed with the timer idle, so the saved time is set
    add_seg(31'd100, 31'd100, 1'b1, 32'd0,    32'd900,  32'd1000, 31'd600, 31'd100, 31'd600, 1'b0);
    add_seg(31'd101, 31'd101, 1'b1, 32'd1000, 32'd950,  32'd1010, 31'd600, 31'd101, 31'd600, 1'b1);
    add_seg(31'd102, 31'd102, 1'b0, 32'd1005, 32'd920,  32'd1020, 31'd600, 31'd102, 31'd600, 1'b1);
    // out of order with and without a running timer
    add_seg(31'd200, 31'd103, 1'b0, 32'd1005, 32'd930,  32'd1030, 31'd600, 31'd103, 31'd600, 1'b1);
    add_seg(31'd201, 31'd104, 1'b0, 32'd1005, 32'd940,  32'd1040, 31'd600, 31'd104, 31'd600, 1'b0);
    // mark inside the round trip is ignored
    add_seg(31'd104, 31'd104, 1'b1, 32'd1005, 32'd945,  32'd1050, 31'd600, 31'd104, 31'd600, 1'b0);
    add_seg(31'd105, 31'd105, 1'b0, 32'd1050, 32'd955,  32'd1060, 31'd600, 31'd105, 31'd600, 1'b1);
    // huge window, factor saturates at the cap
    add_seg(SeqAllOnes, SeqAllOnes, 1'b1, 32'd1060, 32'd960, 32'd1070, SeqAllOnes, 31'd0,
            SeqAllOnes, 1'b0);
    // window far below zero saturates the limit
    add_seg(31'd0, 31'd0, 1'b0, 32'd1070, TimeAllOnes, 32'd1080, 31'd0, SeqAllOnes,
            SeqAllOnes, 1'b1);
    add_seg(31'd106, 31'd106, 1'b0, 32'd1070, 32'd0, 32'd1090, 31'd600, 31'd106, 31'd0, 1'b0);
    add_seg(31'd0, 31'd0, 1'b0, 32'd0, 32'd0, 32'd0, 31'd0, 31'd0, 31'd0, 1'b0);
    add_seg(31'd107, 31'd107, 1'b1, 32'd1080, 32'd10, 32'd1100, 31'd600, 31'd107, 31'd600, 1'b0);
    add_seg(31'd108, 31'd108, 1'b0, 32'd1080, TimeAllOnes, 32'd1110, 31'd600, 31'd108, 31'd600,
            1'b1);
    add_seg(31'd109, 31'd109, 1'b0, 32'd1080, 32'd20, 32'd1120, 31'd600, 31'd109, 31'd600, 1'b1);
    add_seg(31'd110, 31'd110, 1'b0, 32'd1120, 32'd30, 32'd1130, 31'd5, 31'd110, 31'd600, 1'b1);
    add_seg(31'd111, 31'd111, 1'b1, 32'd1130, 32'd40, 32'd1140, 31'd7, 31'd111, 31'd4, 1'b0);
    drain();

    write_max_delay(8'd255);
    jump_ticks(1);
    gen_ramp();
    drain();

    write_max_delay(8'd0);
    jump_ticks(2);
    gen_traffic(30);
    drain();

    write_max_delay(8'd1);
    jump_ticks(3);
    gen_traffic(30);
    drain();

    write_max_delay(CountW'($urandom_range(2, 254)));
    jump_ticks(5);
    gen_traffic(30);
    drain();

    write_max_delay(8'd8);
    jump_ticks(6);
    gen_traffic(30);
    drain();

    // largest echo and arrival times last, since the echo high mark never drops
    write_max_delay(MaxDelayInit);
    add_seg(31'd300, 31'd300, 1'b1, TimeAllOnes, 32'd50, TimeAllOnes, 31'd600, 31'd300,
            31'd600, 1'b0);
    add_seg(31'd301, 31'd301, 1'b1, TimeAllOnes, 32'd60, TimeAllOnes, 31'd600, 31'd301,
            31'd600, 1'b1);
    add_seg(31'd302, 31'd302, 1'b0, 32'd0, 32'd70, 32'd5, 31'd600, 31'd302, 31'd600, 1'b1);
    gen_traffic(30);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/adc_pkg.sv
rtl/adc_front.sv
rtl/adc_back.sv
rtl/adaptive_delayed_ack_control.sv
verif/tb.sv
